// File: design/nsr_pkg.sv
`default_nettype none

package nsr_pkg;

  // Field and datapath widths.
  localparam int FRAC_BITS      = 16;
  localparam int IN_W           = 32;
  localparam int ROOT_W         = 24;
  localparam int CNT_W          = 6;
  localparam int ST_W           = 2;
  localparam int TOL_W          = 16;
  localparam int MAX_ITERATIONS = 32;

  // The shifted radicand, the guess and divider remainder, and the divider step counter.
  localparam int NUM_W     = IN_W - 1 + FRAC_BITS;
  localparam int X_W       = NUM_W + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_NEG = 2'd1;
  localparam logic [ST_W-1:0] ST_CAP = 2'd2;

  // Microprogram control word.
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_COMPARE,
    OP_EMIT_NEG,
    OP_EMIT_ZERO,
    OP_EMIT_OK,
    OP_EMIT_CAP
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_NEG,
    C_ZERO,
    C_DIV_MORE,
    C_CONV,
    C_MORE_ITER,
    C_OUT_WAIT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Flags that the datapath reports to the sequencer.
  typedef struct packed {
    logic in_acc;
    logic neg;
    logic zero;
    logic div_more;
    logic conv;
    logic more_iter;
    logic out_free;
  } dp_flags_t;

  // Labels of the microprogram.
  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_ITER = 4'd3;
  localparam pc_t PC_DIV  = 4'd4;
  localparam pc_t PC_CAP  = 4'd9;
  localparam pc_t PC_NEG  = 4'd10;
  localparam pc_t PC_ZERO = 4'd11;
  localparam pc_t PC_OK   = 4'd12;

  // Control store. Each Newton step runs from PC_ITER through the
  // convergence and iteration-cap checks.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_LOAD,     cond: C_NO_INPUT,  target: PC_IDLE};
      4'd1:    w = '{op: OP_NOP,      cond: C_NEG,       target: PC_NEG};
      4'd2:    w = '{op: OP_NOP,      cond: C_ZERO,      target: PC_ZERO};
      4'd3:    w = '{op: OP_DIV_INIT, cond: C_NEXT,      target: PC_IDLE};
      4'd4:    w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  target: PC_DIV};
      4'd5:    w = '{op: OP_UPDATE,   cond: C_NEXT,      target: PC_IDLE};
      4'd6:    w = '{op: OP_COMPARE,  cond: C_NEXT,      target: PC_IDLE};
      4'd7:    w = '{op: OP_NOP,      cond: C_CONV,      target: PC_OK};
      4'd8:    w = '{op: OP_NOP,      cond: C_MORE_ITER, target: PC_ITER};
      4'd9:    w = '{op: OP_EMIT_CAP, cond: C_OUT_WAIT,  target: PC_IDLE};
      4'd10:   w = '{op: OP_EMIT_NEG, cond: C_OUT_WAIT,  target: PC_IDLE};
      4'd11:   w = '{op: OP_EMIT_ZERO, cond: C_OUT_WAIT, target: PC_IDLE};
      4'd12:   w = '{op: OP_EMIT_OK,  cond: C_OUT_WAIT,  target: PC_IDLE};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/nsr_seq.sv
`default_nettype none

module nsr_seq (
  input  wire               clk,
  input  wire               rst_n,
  input  nsr_pkg::dp_flags_t flags,
  output nsr_pkg::uword_t   uword
);

  nsr_pkg::pc_t pc_r;
  nsr_pkg::pc_t pc_nxt;
  nsr_pkg::pc_t pc_inc;

  // Fetch the control word of the current step.
  assign uword  = nsr_pkg::ucode(pc_r);
  assign pc_inc = pc_r + 1'b1;

  // Select the next step from the jump condition.
  always_comb begin
    case (uword.cond)
      nsr_pkg::C_NEXT:      pc_nxt = pc_inc;
      nsr_pkg::C_ALWAYS:    pc_nxt = uword.target;
      nsr_pkg::C_NO_INPUT:  pc_nxt = flags.in_acc    ? pc_inc       : uword.target;
      nsr_pkg::C_NEG:       pc_nxt = flags.neg       ? uword.target : pc_inc;
      nsr_pkg::C_ZERO:      pc_nxt = flags.zero      ? uword.target : pc_inc;
      nsr_pkg::C_DIV_MORE:  pc_nxt = flags.div_more  ? uword.target : pc_inc;
      nsr_pkg::C_CONV:      pc_nxt = flags.conv      ? uword.target : pc_inc;
      nsr_pkg::C_MORE_ITER: pc_nxt = flags.more_iter ? uword.target : pc_inc;
      nsr_pkg::C_OUT_WAIT:  pc_nxt = flags.out_free  ? uword.target : pc_r;
      default:              pc_nxt = nsr_pkg::PC_IDLE;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= nsr_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/nsr_dpath.sv
`default_nettype none

module nsr_dpath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  nsr_pkg::uword_t                  uword,
  input  wire  [nsr_pkg::TOL_W-1:0]        tol,
  output nsr_pkg::dp_flags_t               flags,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  signed [nsr_pkg::IN_W-1:0]  in_radicand,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [nsr_pkg::ROOT_W-1:0]       out_root,
  output logic [nsr_pkg::CNT_W-1:0]        out_iteration_count,
  output logic [nsr_pkg::ST_W-1:0]         out_status
);

  localparam int X_W   = nsr_pkg::X_W;
  localparam int NUM_W = nsr_pkg::NUM_W;
  localparam int IN_W  = nsr_pkg::IN_W;

  logic [IN_W-1:0]               s_r;
  logic [X_W-1:0]                x_r;
  logic [X_W-1:0]                xn_r;
  logic [X_W-1:0]                rem_r;
  logic [NUM_W-1:0]              quo_r;
  logic [nsr_pkg::DIV_CNT_W-1:0] dcnt_r;
  logic [nsr_pkg::CNT_W-1:0]     cnt_r;
  logic                          conv_r;
  logic                          out_valid_r;
  logic [nsr_pkg::ROOT_W-1:0]    out_root_r;
  logic [nsr_pkg::CNT_W-1:0]     out_cnt_r;
  logic [nsr_pkg::ST_W-1:0]      out_st_r;

  logic                          in_acc;
  logic                          out_free;
  logic [X_W-1:0]                x_first;
  logic [NUM_W-1:0]              num;
  logic [X_W:0]                  rem_sh;
  logic [X_W:0]                  rem_sub;
  logic [X_W:0]                  sum;
  logic [X_W-1:0]                half;
  logic [X_W-1:0]                delta;
  logic [nsr_pkg::ROOT_W-1:0]    root_sat;

  // Handshake.
  assign in_ready  = (uword.op == nsr_pkg::OP_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;
  assign out_iteration_count = out_cnt_r;
  assign out_status = out_st_r;

  // First guess: half the radicand, at least one LSB.
  assign x_first = (in_radicand[IN_W-1:1] == '0) ? X_W'(1)
                 : {{(X_W-IN_W+1){1'b0}}, in_radicand[IN_W-1:1]};

  // The dividend is the radicand shifted up by the fraction width.
  assign num = {s_r[IN_W-2:0], {nsr_pkg::FRAC_BITS{1'b0}}};

  // One restoring division step per cycle.
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, x_r};

  // Newton update: the average of the guess and the quotient.
  assign sum  = {1'b0, x_r} + {{(X_W+1-NUM_W){1'b0}}, quo_r};
  assign half = sum[X_W:1];

  // Distance between successive guesses.
  assign delta = (xn_r >= x_r) ? (xn_r - x_r) : (x_r - xn_r);

  // Root clamps to the width of the result field.
  assign root_sat = (x_r[X_W-1:nsr_pkg::ROOT_W] != '0) ? '1 : x_r[nsr_pkg::ROOT_W-1:0];

  // Flags for the sequencer.
  always_comb begin
    flags.in_acc    = in_acc;
    flags.neg       = s_r[IN_W-1];
    flags.zero      = (s_r == '0);
    flags.div_more  = (dcnt_r != nsr_pkg::DIV_CNT_W'(1));
    flags.conv      = conv_r;
    flags.more_iter = (cnt_r != nsr_pkg::CNT_W'(nsr_pkg::MAX_ITERATIONS));
    flags.out_free  = out_free;
  end

  // Working registers, driven by the current micro-operation.
  always_ff @(posedge clk) begin
    case (uword.op)
      nsr_pkg::OP_LOAD: begin
        if (in_acc) begin
          s_r   <= in_radicand;
          x_r   <= x_first;
          cnt_r <= '0;
        end
      end
      nsr_pkg::OP_DIV_INIT: begin
        rem_r  <= '0;
        quo_r  <= num;
        dcnt_r <= nsr_pkg::DIV_CNT_W'(NUM_W);
      end
      nsr_pkg::OP_DIV_STEP: begin
        if (!rem_sub[X_W]) begin
          rem_r <= rem_sub[X_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[X_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
      end
      nsr_pkg::OP_UPDATE: begin
        xn_r  <= (half == '0) ? X_W'(1) : half;
        cnt_r <= cnt_r + 1'b1;
      end
      nsr_pkg::OP_COMPARE: begin
        conv_r <= (delta <= {{(X_W-nsr_pkg::TOL_W){1'b0}}, tol});
        x_r    <= xn_r;
      end
      default: begin
      end
    endcase
  end

  // Output register: a result waits here while the next item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      case (uword.op)
        nsr_pkg::OP_EMIT_NEG,
        nsr_pkg::OP_EMIT_ZERO,
        nsr_pkg::OP_EMIT_OK,
        nsr_pkg::OP_EMIT_CAP: out_valid_r <= 1'b1;
        default:              out_valid_r <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      case (uword.op)
        nsr_pkg::OP_EMIT_NEG: begin
          out_root_r <= '0;
          out_cnt_r  <= '0;
          out_st_r   <= nsr_pkg::ST_NEG;
        end
        nsr_pkg::OP_EMIT_ZERO: begin
          out_root_r <= '0;
          out_cnt_r  <= '0;
          out_st_r   <= nsr_pkg::ST_OK;
        end
        nsr_pkg::OP_EMIT_OK: begin
          out_root_r <= root_sat;
          out_cnt_r  <= cnt_r;
          out_st_r   <= nsr_pkg::ST_OK;
        end
        nsr_pkg::OP_EMIT_CAP: begin
          out_root_r <= root_sat;
          out_cnt_r  <= cnt_r;
          out_st_r   <= nsr_pkg::ST_CAP;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/newton_square_root_fixed.sv
`default_nettype none

// Newton-Raphson square root of a signed Q16.16 radicand, returned as unsigned
// Q8.16 with the number of Newton steps taken and a status (converged,
// negative input, or iteration cap of 32 steps reached). Items are handled one
// at a time. A negative or zero radicand skips the Newton steps. Otherwise each
// Newton step has a divider setup, a restoring divider that retires one
// quotient bit per cycle over the 47-bit shifted radicand, then the update and
// checks; the step that converges skips the last check. Typically 20 steps or
// fewer suffice for a tolerance of one LSB. Finished results wait in an output
// register, so the next item is accepted while a result is still pending. The
// user must write the tolerance register (byte address 0, reset 1) only while
// idle; the block itself does not enforce this.
module newton_square_root_fixed (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  signed [nsr_pkg::IN_W-1:0]   in_radicand,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [nsr_pkg::ROOT_W-1:0]        out_root,
  output logic [nsr_pkg::CNT_W-1:0]         out_iteration_count,
  output logic [nsr_pkg::ST_W-1:0]          out_status,
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire  [nsr_pkg::APB_AW-1:0]        cfg_paddr,
  input  wire  [nsr_pkg::APB_DW-1:0]        cfg_pwdata,
  output logic [nsr_pkg::APB_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  logic [nsr_pkg::TOL_W-1:0] tol_r;
  logic                      tol_sel;
  nsr_pkg::uword_t           uword;
  nsr_pkg::dp_flags_t        flags;

  // Register file: one tolerance register.
  assign cfg_pready = 1'b1;
  assign tol_sel    = (cfg_paddr[2] == nsr_pkg::REG_TOLERANCE);
  assign cfg_prdata = tol_sel ? {{(nsr_pkg::APB_DW-nsr_pkg::TOL_W){1'b0}}, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= nsr_pkg::TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && tol_sel) begin
      tol_r <= cfg_pwdata[nsr_pkg::TOL_W-1:0];
    end
  end

  // Microprogram sequencer.
  nsr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uword (uword)
  );

  // Datapath with divider and output register.
  nsr_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .uword               (uword),
    .tol                 (tol_r),
    .flags               (flags),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_radicand         (in_radicand),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_root            (out_root),
    .out_iteration_count (out_iteration_count),
    .out_status          (out_status)
  );

endmodule

`default_nettype wire

// File: design/nsr_checker.sv
`default_nettype none

module nsr_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_ready,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [nsr_pkg::ROOT_W-1:0]        out_root,
  input wire [nsr_pkg::CNT_W-1:0]         out_iteration_count,
  input wire [nsr_pkg::ST_W-1:0]          out_status
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_root)
      && $stable(out_iteration_count) && $stable(out_status))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an item");

  // A negative radicand reports a zero root after no steps.
  a_neg_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == nsr_pkg::ST_NEG |-> out_root == '0
      && out_iteration_count == '0)
    else $error("negative item gave a nonzero root or count");

  // The cap status appears only after the full number of steps.
  a_cap_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == nsr_pkg::ST_CAP
      |-> out_iteration_count == nsr_pkg::CNT_W'(nsr_pkg::MAX_ITERATIONS))
    else $error("cap status with a short step count");

  // Converging after no steps happens only for a zero radicand.
  a_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == nsr_pkg::ST_OK && out_iteration_count == '0
      |-> out_root == '0)
    else $error("converged without steps but root is nonzero");

endmodule

bind newton_square_root_fixed nsr_checker u_nsr_checker (.*);

`default_nettype wire

// File: sim/tb_newton_square_root_fixed.sv
`default_nettype none

module tb_newton_square_root_fixed;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int MAX_PRINTED = 40;
  localparam logic [nsr_pkg::APB_AW-1:0] TOL_ADDR =
    nsr_pkg::APB_AW'(4 * int'(nsr_pkg::REG_TOLERANCE));

  typedef struct packed {
    logic [nsr_pkg::IN_W-1:0]   radicand;
    logic [nsr_pkg::ROOT_W-1:0] root;
    logic [nsr_pkg::CNT_W-1:0]  count;
    logic [nsr_pkg::ST_W-1:0]   status;
  } root_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic signed [nsr_pkg::IN_W-1:0] in_radicand = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [nsr_pkg::ROOT_W-1:0]      out_root;
  logic [nsr_pkg::CNT_W-1:0]       out_iteration_count;
  logic [nsr_pkg::ST_W-1:0]        out_status;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [nsr_pkg::APB_AW-1:0]      cfg_paddr = '0;
  logic [nsr_pkg::APB_DW-1:0]      cfg_pwdata = '0;
  logic [nsr_pkg::APB_DW-1:0]      cfg_prdata;
  logic                            cfg_pready;

  // Testbench copy of the tolerance register and the item bookkeeping.
  logic [nsr_pkg::TOL_W-1:0]  tol_setting = nsr_pkg::TOL_RESET;
  logic [nsr_pkg::IN_W-1:0]   pending_radicands[$];
  root_result_t               expected_roots[$];
  bit                         quiet_mode = 1'b0;
  int                         fail_count = 0;
  int                         send_wait = 0;
  int                         recv_wait = 0;
  int                         hold_left = 0;
  int                         results_seen = 0;
  int                         idle_cycles = 0;

  newton_square_root_fixed u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_radicand         (in_radicand),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_root            (out_root),
    .out_iteration_count (out_iteration_count),
    .out_status          (out_status),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  always #5 clk = ~clk;

  // Newton-Raphson in exact unsigned integers, truncating every division and halving.
  function automatic root_result_t newton_root(logic [nsr_pkg::IN_W-1:0] rad,
                                               logic [nsr_pkg::TOL_W-1:0] tol);
    root_result_t r;
    logic [63:0]  num;
    logic [63:0]  x;
    logic [63:0]  xn;
    logic [63:0]  diff;
    int unsigned  steps;
    bit           conv;
    r.radicand = rad;
    r.root = '0;
    r.count = '0;
    conv = 1'b0;
    steps = 0;
    if (rad[nsr_pkg::IN_W-1]) begin
      r.status = nsr_pkg::ST_NEG;
      return r;
    end
    if (rad == '0) begin
      r.status = nsr_pkg::ST_OK;
      return r;
    end
    num = 64'(rad) << nsr_pkg::FRAC_BITS;
    x = 64'(rad) >> 1;
    if (x == 64'd0) x = 64'd1;
    while (steps < nsr_pkg::MAX_ITERATIONS && !conv) begin
      xn = (x + num / x) >> 1;
      if (xn == 64'd0) xn = 64'd1;
      steps++;
      diff = (xn >= x) ? (xn - x) : (x - xn);
      x = xn;
      conv = (diff <= 64'(tol));
    end
    r.root = (x > 64'({nsr_pkg::ROOT_W{1'b1}})) ? {nsr_pkg::ROOT_W{1'b1}}
           : x[nsr_pkg::ROOT_W-1:0];
    r.count = (steps > 63) ? {nsr_pkg::CNT_W{1'b1}} : nsr_pkg::CNT_W'(steps);
    r.status = conv ? nsr_pkg::ST_OK : nsr_pkg::ST_CAP;
    return r;
  endfunction

  // Radicands spread over sign, magnitude, tiny values and exact squares.
  function automatic logic [nsr_pkg::IN_W-1:0] random_radicand();
    logic [nsr_pkg::IN_W-1:0] v;
    int unsigned              r;
    case ($urandom_range(0, 9))
      0: v = $urandom | 32'h8000_0000;
      1: v = ($urandom_range(0, 3) == 0) ? '0 : nsr_pkg::IN_W'($urandom_range(1, 16));
      2: begin
        r = $urandom_range(1, 181);
        v = nsr_pkg::IN_W'((r * r) << nsr_pkg::FRAC_BITS);
      end
      3, 4: v = $urandom >> $urandom_range(1, 31);
      default: v = $urandom & 32'h7FFF_FFFF;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_result(input logic [nsr_pkg::ROOT_W-1:0] root,
                              input logic [nsr_pkg::CNT_W-1:0] cnt,
                              input logic [nsr_pkg::ST_W-1:0] st);
    root_result_t e;
    if (expected_roots.size() == 0) begin
      report_mismatch($sformatf("unexpected result root=%h count=%0d status=%0d",
                                root, cnt, st));
      return;
    end
    e = expected_roots.pop_front();
    if (root !== e.root)
      report_mismatch($sformatf("radicand %h: root %h, expected %h", e.radicand, root, e.root));
    if (cnt !== e.count)
      report_mismatch($sformatf("radicand %h: iteration_count %0d, expected %0d",
                                e.radicand, cnt, e.count));
    if (st !== e.status)
      report_mismatch($sformatf("radicand %h: status %0d, expected %0d",
                                e.radicand, st, e.status));
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_radicands.push_back(random_radicand());
  endtask

  // Extremes, exact squares, sub-LSB halves and alternating bit patterns.
  task automatic queue_corner_cases();
    pending_radicands.push_back(32'h0000_0000);
    pending_radicands.push_back(32'h0000_0001);
    pending_radicands.push_back(32'h0000_0002);
    pending_radicands.push_back(32'h0000_0003);
    pending_radicands.push_back(32'h7FFF_FFFF);
    pending_radicands.push_back(32'h8000_0000);
    pending_radicands.push_back(32'hFFFF_FFFF);
    pending_radicands.push_back(32'h0001_0000);
    pending_radicands.push_back(32'h0004_0000);
    pending_radicands.push_back(32'h0009_0000);
    pending_radicands.push_back(32'h0002_0000);
    pending_radicands.push_back(32'h0000_FFFF);
    pending_radicands.push_back(32'h0000_8000);
    pending_radicands.push_back(32'h7FFF_0000);
    pending_radicands.push_back(32'h4000_0000);
    pending_radicands.push_back(32'h5555_5555);
    pending_radicands.push_back(32'h2AAA_AAAA);
    pending_radicands.push_back(32'hAAAA_AAAA);
    pending_radicands.push_back(32'h0000_0100);
    pending_radicands.push_back(32'h0100_0000);
  endtask

  // Waits until every queued item has been sent and answered, then lets the block settle.
  task automatic drain();
    while (pending_radicands.size() != 0 || in_valid || expected_roots.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [nsr_pkg::TOL_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= TOL_ADDR;
    cfg_pwdata <= nsr_pkg::APB_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tol_setting = val;
    @(negedge clk);
  endtask

  // Sender: offers queued radicands, with a random gap after each item unless in quiet mode.
  always @(posedge clk) begin : radicand_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_roots.push_back(newton_root(in_radicand, tol_setting));
      if (send_wait != 0) begin
        in_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_radicands.size() != 0) begin
        in_radicand <= pending_radicands.pop_front();
        in_valid <= 1'b1;
        send_wait <= quiet_mode ? 0 : $urandom_range(0, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result and, outside quiet mode, stalls at random, with two long hold-offs.
  always @(posedge clk) begin : result_monitor
    logic rdy_next;
    int   w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
      results_seen <= 0;
    end else begin
      rdy_next = out_ready;
      if (out_valid && out_ready) begin
        check_result(out_root, out_iteration_count, out_status);
        results_seen <= results_seen + 1;
        if (results_seen == 40 || results_seen == 450) begin
          hold_left <= HOLD_CYCLES;
          rdy_next = 1'b0;
        end else begin
          w = quiet_mode ? 0 : $urandom_range(0, 19);
          rdy_next = (w == 0);
          if (w != 0) recv_wait <= w - 1;
        end
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
      end else begin
        rdy_next = 1'b1;
      end
      out_ready <= rdy_next;
    end
  end

  // Ends the run if no item is accepted or delivered and no register access happens for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset tolerance of one LSB: corner cases, then random items.
    queue_corner_cases();
    queue_random(200);
    drain();

    // Zero tolerance: oscillating guesses run into the iteration cap.
    write_tolerance('0);
    queue_random(60);
    drain();

    // Widest tolerance, with no idling on either side.
    quiet_mode = 1'b1;
    write_tolerance({nsr_pkg::TOL_W{1'b1}});
    queue_corner_cases();
    queue_random(100);
    drain();
    quiet_mode = 1'b0;

    // A random moderate tolerance.
    write_tolerance(nsr_pkg::TOL_W'($urandom_range(2, 4095)));
    queue_random(140);
    drain();

    // Back to one LSB, written explicitly.
    write_tolerance(nsr_pkg::TOL_RESET);
    queue_random(60);
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
